/* hw/rtl/chta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package chta_pkg;

  // Default store geometry along each axis.
  localparam int DEFAULT_MAX_LUM_BINS   = 16;
  localparam int DEFAULT_MAX_COLOR_BINS = 16;

  // Field widths of the command and result ports.
  localparam int PIX_W        = 8;
  localparam int WEIGHT_W     = 16;
  localparam int READ_INDEX_W = 12;
  localparam int BIN_W        = 32;
  localparam int TOTAL_W      = 40;

  // A bin index along one axis covers up to 64 bins; a count needs one bit more.
  localparam int BIN_IDX_W = 6;
  localparam int COUNT_W   = BIN_IDX_W + 1;

  // Axis weights are Q1.8 and reach 256.
  localparam int AXIS_WT_W = 9;

  // Configuration port.
  localparam int CFG_W       = 5;
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_LUM_BINS   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_BINS = 4'd1;
  localparam logic [CFG_W-1:0]       LUM_BINS_RESET   = 5'd8;
  localparam logic [CFG_W-1:0]       COLOR_BINS_RESET = 5'd16;

  // Command codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Lower and upper neighbor of one channel with their interpolation weights.
  typedef struct packed {
    logic [BIN_IDX_W-1:0] lo;
    logic [BIN_IDX_W-1:0] hi;
    logic [AXIS_WT_W-1:0] w_lo;
    logic [AXIS_WT_W-1:0] w_hi;
  } axis_t;

endpackage

`default_nettype wire

/* hw/rtl/color_histogram_trilinear_accumulate.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Carries
// command   start / busy            op, lum_value, color_one, color_two, pixel_weight,
//                                   read_index
// result    done (one-cycle strobe) bin_value, total_weight, saturated
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An add runs from start to done through the position math, then the bin offsets;
// the eight bin updates then issue one per cycle into a four-stage read / multiply /
// write-back pipeline on the bin memory, plus drain and finish.
// A read does one memory read with registered data, then registers the result.
// After reset the bin memory is swept to zero, one entry per cycle, across all
// MAX_LUM_BINS*MAX_COLOR_BINS^2 entries (4096 by default) with busy held high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module color_histogram_trilinear_accumulate #(
  parameter int MAX_LUM_BINS   = chta_pkg::DEFAULT_MAX_LUM_BINS,
  parameter int MAX_COLOR_BINS = chta_pkg::DEFAULT_MAX_COLOR_BINS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic                              op,
  input  wire logic [chta_pkg::PIX_W-1:0]        lum_value,
  input  wire logic [chta_pkg::PIX_W-1:0]        color_one,
  input  wire logic [chta_pkg::PIX_W-1:0]        color_two,
  input  wire logic [chta_pkg::WEIGHT_W-1:0]     pixel_weight,
  input  wire logic [chta_pkg::READ_INDEX_W-1:0] read_index,
  output      logic                              done,
  output      logic [chta_pkg::BIN_W-1:0]        bin_value,
  output      logic [chta_pkg::TOTAL_W-1:0]      total_weight,
  output      logic                              saturated,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [chta_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [chta_pkg::CFG_W-1:0]        cfg_data
);

  localparam int DEPTH   = MAX_LUM_BINS * MAX_COLOR_BINS * MAX_COLOR_BINS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CMP_W   = ((ADDR_W > chta_pkg::READ_INDEX_W) ? ADDR_W
                                                             : chta_pkg::READ_INDEX_W) + 1;
  localparam int CNT_W   = chta_pkg::COUNT_W;
  localparam int NC2_W   = 2 * CNT_W;
  localparam int LPROD_W = chta_pkg::BIN_IDX_W + NC2_W;
  localparam int CPROD_W = chta_pkg::BIN_IDX_W + CNT_W;
  localparam int WT_W    = chta_pkg::AXIS_WT_W;
  // Product of two, then three, Q1.8 weights (each at most 256), then times the weight.
  localparam int M1_W    = 2 * WT_W - 1;
  localparam int M2_W    = 3 * WT_W - 2;
  localparam int M3_W    = M2_W + chta_pkg::WEIGHT_W - 1;
  localparam int SHIFT   = 24;
  localparam int BW      = chta_pkg::BIN_W;
  localparam int TW      = chta_pkg::TOTAL_W;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_POS    = 11'b000_0000_0100,
    ST_FRAC   = 11'b000_0000_1000,
    ST_SPLIT  = 11'b000_0001_0000,
    ST_OFFS   = 11'b000_0010_0000,
    ST_CORNER = 11'b000_0100_0000,
    ST_DRAIN  = 11'b000_1000_0000,
    ST_FINISH = 11'b001_0000_0000,
    ST_READ   = 11'b010_0000_0000,
    ST_RDATA  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration.
  logic [chta_pkg::CFG_W-1:0] lum_cfg, color_cfg;
  logic [CNT_W-1:0]           lum_n, color_n;
  logic [NC2_W-1:0]           color_sq;

  // Captured command.
  logic [chta_pkg::PIX_W-1:0]        pix_cap [3];
  logic [chta_pkg::WEIGHT_W-1:0]     wt_cap;
  logic [chta_pkg::READ_INDEX_W-1:0] ridx_cap;
  logic [CMP_W-1:0]                  ridx_ext;
  logic                              rd_in_range;

  chta_pkg::axis_t ax [3];

  // Flat offsets of lower and upper neighbor per axis.
  logic [LPROD_W-1:0] lum_prod [2];
  logic [CPROD_W-1:0] c1_prod [2];
  logic [ADDR_W-1:0]  lum_off [2];
  logic [ADDR_W-1:0]  c1_off [2];
  logic [ADDR_W-1:0]  c2_off [2];

  // Corner pipeline.
  logic [2:0]         corner;
  logic               issue;
  logic [WT_W-1:0]    w_lum_sel, w_c1_sel, w_c2_sel;
  logic [ADDR_W-1:0]  idx_p0;
  logic [M1_W-1:0]    m1;
  logic [WT_W-1:0]    w2_p1;
  logic [ADDR_W-1:0]  idx_p1, idx_p2, idx_p3;
  logic [M2_W-1:0]    m2;
  logic [M3_W-1:0]    m3;
  logic               v_p1, v_p2, v_p3;
  logic [M3_W-SHIFT-1:0] contrib;
  logic [BW-1:0]      src;
  logic [BW:0]        bin_sum;
  logic [BW-1:0]      bin_sat;

  // Write-back bypass for back-to-back updates of the same bin.
  logic               fwd_valid;
  logic [ADDR_W-1:0]  fwd_addr;
  logic [BW-1:0]      fwd_data;

  // Bin memory.
  logic [BW-1:0]      bin_mem [DEPTH];
  logic [BW-1:0]      rdata;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [BW-1:0]      wr_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  clear_addr;

  // Running sums.
  logic [TW-1:0]      total;
  logic               sat_flag;
  logic [TW:0]        total_sum;
  logic [TW-1:0]      total_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lum_cfg   <= chta_pkg::LUM_BINS_RESET;
      color_cfg <= chta_pkg::COLOR_BINS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        chta_pkg::REG_LUM_BINS:   lum_cfg   <= cfg_data;
        chta_pkg::REG_COLOR_BINS: color_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero count means one bin; counts above the store geometry are clipped.
  always_comb begin
    if (lum_cfg == '0) begin
      lum_n = CNT_W'(1);
    end else if (CNT_W'(lum_cfg) > CNT_W'(MAX_LUM_BINS)) begin
      lum_n = CNT_W'(MAX_LUM_BINS);
    end else begin
      lum_n = CNT_W'(lum_cfg);
    end
    if (color_cfg == '0) begin
      color_n = CNT_W'(1);
    end else if (CNT_W'(color_cfg) > CNT_W'(MAX_COLOR_BINS)) begin
      color_n = CNT_W'(MAX_COLOR_BINS);
    end else begin
      color_n = CNT_W'(color_cfg);
    end
  end

  always_ff @(posedge clk) begin
    color_sq <= NC2_W'(color_n) * NC2_W'(color_n);
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pix_cap[0] <= lum_value;
      pix_cap[1] <= color_one;
      pix_cap[2] <= color_two;
      wt_cap     <= pixel_weight;
      ridx_cap   <= read_index;
    end
  end

  chta_axis u_axis_lum (
    .clk      (clk),
    .pix      (pix_cap[0]),
    .n_minus1 (chta_pkg::BIN_IDX_W'(lum_n - CNT_W'(1))),
    .axis     (ax[0])
  );

  chta_axis u_axis_c1 (
    .clk      (clk),
    .pix      (pix_cap[1]),
    .n_minus1 (chta_pkg::BIN_IDX_W'(color_n - CNT_W'(1))),
    .axis     (ax[1])
  );

  chta_axis u_axis_c2 (
    .clk      (clk),
    .pix      (pix_cap[2]),
    .n_minus1 (chta_pkg::BIN_IDX_W'(color_n - CNT_W'(1))),
    .axis     (ax[2])
  );

  always_comb begin
    lum_prod[0] = LPROD_W'(ax[0].lo) * LPROD_W'(color_sq);
    lum_prod[1] = LPROD_W'(ax[0].hi) * LPROD_W'(color_sq);
    c1_prod[0]  = CPROD_W'(ax[1].lo) * CPROD_W'(color_n);
    c1_prod[1]  = CPROD_W'(ax[1].hi) * CPROD_W'(color_n);
  end

  always_ff @(posedge clk) begin
    if (state == ST_OFFS) begin
      lum_off[0] <= ADDR_W'(lum_prod[0]);
      lum_off[1] <= ADDR_W'(lum_prod[1]);
      c1_off[0]  <= ADDR_W'(c1_prod[0]);
      c1_off[1]  <= ADDR_W'(c1_prod[1]);
      c2_off[0]  <= ADDR_W'(ax[2].lo);
      c2_off[1]  <= ADDR_W'(ax[2].hi);
    end
  end

  // Corner order: luminance neighbor is the slowest digit, color two the fastest.
  assign issue = (state == ST_CORNER);

  always_comb begin
    w_lum_sel = corner[2] ? ax[0].w_hi : ax[0].w_lo;
    w_c1_sel  = corner[1] ? ax[1].w_hi : ax[1].w_lo;
    w_c2_sel  = corner[0] ? ax[2].w_hi : ax[2].w_lo;
    idx_p0    = lum_off[corner[2]] + c1_off[corner[1]] + c2_off[corner[0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= '0;
      v_p1   <= 1'b0;
      v_p2   <= 1'b0;
      v_p3   <= 1'b0;
    end else begin
      if (state == ST_OFFS) begin
        corner <= '0;
      end else if (issue) begin
        corner <= corner + 3'd1;
      end
      v_p1 <= issue;
      v_p2 <= v_p1;
      v_p3 <= v_p2;
    end
  end

  always_ff @(posedge clk) begin
    m1     <= M1_W'(w_lum_sel) * M1_W'(w_c1_sel);
    w2_p1  <= w_c2_sel;
    idx_p1 <= idx_p0;
    m2     <= M2_W'(m1) * M2_W'(w2_p1);
    idx_p2 <= idx_p1;
    m3     <= M3_W'(m2) * M3_W'(wt_cap);
    idx_p3 <= idx_p2;
  end

  always_comb begin
    contrib = m3[M3_W-1:SHIFT];
    src     = (fwd_valid && (fwd_addr == idx_p3)) ? fwd_data : rdata;
    bin_sum = {1'b0, src} + (BW+1)'(contrib);
    bin_sat = bin_sum[BW] ? {BW{1'b1}} : bin_sum[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= v_p3;
    end
    fwd_addr <= idx_p3;
    fwd_data <= bin_sat;
  end

  always_comb begin
    ridx_ext    = CMP_W'(ridx_cap);
    rd_in_range = (ridx_ext < CMP_W'(DEPTH));
    rd_addr     = (state == ST_READ) ? ridx_ext[ADDR_W-1:0] : idx_p2;
    wr_en       = (state == ST_CLEAR) || v_p3;
    wr_addr     = (state == ST_CLEAR) ? clear_addr : idx_p3;
    wr_data     = (state == ST_CLEAR) ? '0 : bin_sat;
  end

  always_ff @(posedge clk) begin
    rdata <= bin_mem[rd_addr];
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (op == chta_pkg::OP_ADD) ? ST_POS : ST_READ;
        end
      end
      ST_POS:    state_next = ST_FRAC;
      ST_FRAC:   state_next = ST_SPLIT;
      ST_SPLIT:  state_next = ST_OFFS;
      ST_OFFS:   state_next = ST_CORNER;
      ST_CORNER: begin
        if (corner == 3'd7) state_next = ST_DRAIN;
      end
      // The last write-back may still be in flight; the finish step does not
      // touch the memory, only the flag that the write-back updates this edge.
      ST_DRAIN: begin
        if (!v_p1 && !v_p2) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_IDLE;
      ST_READ:   state_next = ST_RDATA;
      ST_RDATA:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    total_sum  = {1'b0, total} + (TW+1)'(wt_cap);
    total_next = total_sum[TW] ? {TW{1'b1}} : total_sum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      sat_flag <= 1'b0;
    end else begin
      if (state == ST_FINISH) begin
        total <= total_next;
      end
      sat_flag <= sat_flag | (v_p3 & bin_sum[BW]) |
                  ((state == ST_FINISH) & total_sum[TW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      bin_value    <= '0;
      total_weight <= '0;
      saturated    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == ST_FINISH) begin
        done         <= 1'b1;
        bin_value    <= '0;
        total_weight <= total_next;
        saturated    <= sat_flag | total_sum[TW];
      end else if (state == ST_RDATA) begin
        done         <= 1'b1;
        bin_value    <= rd_in_range ? rdata : '0;
        total_weight <= total;
        saturated    <= sat_flag;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/chta_axis.sv */
`timescale 1ns / 1ps
`default_nettype none

// Three-stage position pipeline for one channel: pos = floor(pix * (n-1) * 256 / 255)
// in Q.8, split into lower bin, upper bin and the two axis weights.
module chta_axis (
  input  wire logic                           clk,
  input  wire logic [chta_pkg::PIX_W-1:0]     pix,
  input  wire logic [chta_pkg::BIN_IDX_W-1:0] n_minus1,
  output chta_pkg::axis_t                     axis
);

  localparam int Y_W    = chta_pkg::PIX_W + chta_pkg::BIN_IDX_W;
  localparam int PROD_W = Y_W + 9;
  localparam int Q_W    = PROD_W - 16;
  localparam int FRAC_W = 8;

  logic [Y_W-1:0]    y;
  logic [Y_W-1:0]    pos;
  logic [PROD_W-1:0] prod257;
  logic [Q_W-1:0]    q_est;
  logic [Y_W-1:0]    rem;
  logic [Q_W-1:0]    q;
  logic [FRAC_W-1:0] frac;
  logic [chta_pkg::BIN_IDX_W-1:0] lo;

  // floor(256*y/255) = y + floor(y/255). The quotient estimate y*257 >> 16 is at
  // most one low, so a single compare against 255 corrects it.
  always_comb begin
    prod257 = PROD_W'(y) * PROD_W'(257);
    q_est   = prod257[PROD_W-1:16];
    rem     = y - ((Y_W'(q_est) << 8) - Y_W'(q_est));
    q       = q_est + Q_W'(rem >= Y_W'(255));
    frac    = pos[FRAC_W-1:0];
    lo      = pos[Y_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    y         <= Y_W'(pix) * Y_W'(n_minus1);
    pos       <= y + Y_W'(q);
    axis.lo   <= lo;
    axis.hi   <= lo + chta_pkg::BIN_IDX_W'(frac != '0);
    axis.w_lo <= chta_pkg::AXIS_WT_W'(256) - chta_pkg::AXIS_WT_W'(frac);
    axis.w_hi <= chta_pkg::AXIS_WT_W'(frac);
  end

endmodule

`default_nettype wire

/* hw/rtl/chta_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module chta_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done,
  input wire logic [chta_pkg::TOTAL_W-1:0] total_weight,
  input wire logic                         saturated
);

  // Every result closes a command that kept the block busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Result fields only move with a result beat.
  a_hold_between: assert property (@(posedge clk) disable iff (rst)
    !done |-> ($stable(total_weight) && $stable(saturated)))
    else $error("result fields changed without a result beat");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    done |-> (total_weight >= $past(total_weight)))
    else $error("weight sum decreased");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(saturated))
    else $error("saturation flag cleared");

endmodule

bind color_histogram_trilinear_accumulate chta_checker u_chta_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .total_weight (total_weight),
  .saturated    (saturated)
);

`default_nettype wire
